/* hdl/mpbt_pkg.sv */
package mpbt_pkg;

    localparam int MAX_WIDTH  = 256;
    localparam int MAX_HEIGHT = 256;

    localparam int COL_W = $clog2(MAX_WIDTH);
    localparam int ROW_W = $clog2(MAX_HEIGHT);
    localparam int WD_W  = $clog2(MAX_WIDTH + 1);
    localparam int HT_W  = $clog2(MAX_HEIGHT + 1);

    localparam int QDEPTH = 2;

    localparam logic [1:0] CFG_VTHR   = 2'd0;
    localparam logic [1:0] CFG_HTHR   = 2'd1;
    localparam logic [1:0] CFG_MARGIN = 2'd2;

    typedef struct packed {
        logic [8:0] vthr;
        logic [8:0] hthr;
        logic [7:0] margin;
    } t_cfg;

    typedef struct packed {
        logic                 wr;
        logic                 done;
        logic [ROW_W-1:0]     row;
        logic [MAX_WIDTH-1:0] data;
        logic                 found;
        logic [ROW_W-1:0]     first;
        logic [HT_W-1:0]      rows_valid;
        logic [11:0]          x;
        logic [11:0]          y;
        logic [WD_W-1:0]      w;
        logic [HT_W-1:0]      h;
    } t_cmd;

endpackage

/* hdl/mask_projection_box_trim.sv */
// Trims a box against a binary foreground mask. A start item (mode 0) loads the box; pixel
// items (mode 1) follow in row-major order and are taken one per cycle while the two-entry
// row queue has room. The item with the last flag hands the box to the back end, which reads
// the stored rows through the single read port of the row memory, from the top-trim row
// down to the bottom, to build column counts, then walks the columns once. Pixel items for
// the next box keep flowing meanwhile until the queue fills. Configuration writes take
// effect at once.
module mask_projection_box_trim (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_cfg_we,
    input  logic [1:0]  i_cfg_idx,
    input  logic [8:0]  i_cfg_data,
    input  logic        i_valid,
    output logic        o_ready,
    input  logic        i_mode,
    input  logic [11:0] i_box_x,
    input  logic [11:0] i_box_y,
    input  logic [8:0]  i_box_width,
    input  logic [8:0]  i_box_height,
    input  logic        i_pixel_on,
    input  logic        i_last_pixel,
    output logic        o_valid,
    input  logic        i_ready,
    output logic [11:0] o_out_x,
    output logic [11:0] o_out_y,
    output logic [8:0]  o_out_width,
    output logic [8:0]  o_out_height
);
    import mpbt_pkg::*;

    t_cfg r_cfg;
    t_cmd push_cmd, head_cmd;
    logic push, full, pop, q_valid;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.vthr   <= 9'd10;
            r_cfg.hthr   <= 9'd10;
            r_cfg.margin <= 8'd10;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                CFG_VTHR:   r_cfg.vthr   <= i_cfg_data;
                CFG_HTHR:   r_cfg.hthr   <= i_cfg_data;
                CFG_MARGIN: r_cfg.margin <= i_cfg_data[7:0];
                default: begin
                end
            endcase
        end
    end

    mpbt_front u_front (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_valid      (i_valid),
        .o_ready      (o_ready),
        .i_mode       (i_mode),
        .i_box_x      (i_box_x),
        .i_box_y      (i_box_y),
        .i_box_width  (i_box_width),
        .i_box_height (i_box_height),
        .i_pixel_on   (i_pixel_on),
        .i_last_pixel (i_last_pixel),
        .i_cfg        (r_cfg),
        .o_cmd        (push_cmd),
        .o_push       (push),
        .i_full       (full)
    );

    mpbt_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_cmd   (push_cmd),
        .o_full  (full),
        .i_pop   (pop),
        .o_valid (q_valid),
        .o_cmd   (head_cmd)
    );

    mpbt_back u_back (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cfg        (r_cfg),
        .i_q_valid    (q_valid),
        .i_cmd        (head_cmd),
        .o_pop        (pop),
        .o_valid      (o_valid),
        .i_ready      (i_ready),
        .o_out_x      (o_out_x),
        .o_out_y      (o_out_y),
        .o_out_width  (o_out_width),
        .o_out_height (o_out_height)
    );

endmodule

/* hdl/mpbt_front.sv */
module mpbt_front (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_valid,
    output logic          o_ready,
    input  logic          i_mode,
    input  logic [11:0]   i_box_x,
    input  logic [11:0]   i_box_y,
    input  logic [8:0]    i_box_width,
    input  logic [8:0]    i_box_height,
    input  logic          i_pixel_on,
    input  logic          i_last_pixel,
    input  mpbt_pkg::t_cfg i_cfg,
    output mpbt_pkg::t_cmd o_cmd,
    output logic          o_push,
    input  logic          i_full
);
    import mpbt_pkg::*;

    logic [11:0]          r_x, r_y;
    logic [WD_W-1:0]      r_w;
    logic [HT_W-1:0]      r_h;
    logic [COL_W-1:0]     r_col;
    logic [HT_W-1:0]      r_row;
    logic [MAX_WIDTH-1:0] r_buf, n_buf;
    logic [WD_W-1:0]      r_cnt, n_cnt;
    logic                 r_found;
    logic [ROW_W-1:0]     r_first;

    logic        accept, in_box, row_end, eval, qualify;
    logic [15:0] w16, bw16, bh16, thr16, vthr16;
    logic [WD_W-1:0] cl_w;
    logic [HT_W-1:0] cl_h;

    assign o_ready = !i_full;
    assign accept  = i_valid && o_ready;

    assign w16    = 16'(r_w);
    assign bw16   = {7'b0, i_box_width};
    assign bh16   = {7'b0, i_box_height};
    assign vthr16 = {7'b0, i_cfg.vthr};
    assign thr16  = (vthr16 < w16) ? vthr16 : w16;

    always_comb begin
        if (bw16 == 16'd0) begin
            cl_w = WD_W'(1);
        end else if (bw16 > 16'(MAX_WIDTH)) begin
            cl_w = WD_W'(MAX_WIDTH);
        end else begin
            cl_w = WD_W'(bw16);
        end
        if (bh16 == 16'd0) begin
            cl_h = HT_W'(1);
        end else if (bh16 > 16'(MAX_HEIGHT)) begin
            cl_h = HT_W'(MAX_HEIGHT);
        end else begin
            cl_h = HT_W'(bh16);
        end
    end

    always_comb begin
        in_box = r_row < r_h;
        n_buf  = r_buf;
        n_cnt  = r_cnt;
        if (in_box) begin
            n_buf[r_col] = r_buf[r_col] | i_pixel_on;
            n_cnt        = r_cnt + WD_W'(i_pixel_on);
        end
        row_end = in_box && (16'(r_col) == w16 - 16'd1);
        eval    = row_end || (i_last_pixel && in_box);
        qualify = eval && !r_found && (16'(n_cnt) >= thr16);
    end

    assign o_push = accept && i_mode && (row_end || i_last_pixel);

    always_comb begin
        o_cmd.wr         = in_box;
        o_cmd.done       = i_last_pixel;
        o_cmd.row        = r_row[ROW_W-1:0];
        o_cmd.data       = n_buf;
        o_cmd.found      = r_found || qualify;
        o_cmd.first      = qualify ? r_row[ROW_W-1:0] : r_first;
        o_cmd.rows_valid = in_box ? r_row + HT_W'(1) : r_row;
        o_cmd.x          = r_x;
        o_cmd.y          = r_y;
        o_cmd.w          = r_w;
        o_cmd.h          = r_h;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_x     <= '0;
            r_y     <= '0;
            r_w     <= WD_W'(1);
            r_h     <= HT_W'(1);
            r_col   <= '0;
            r_row   <= '0;
            r_buf   <= '0;
            r_cnt   <= '0;
            r_found <= 1'b0;
            r_first <= '0;
        end else if (accept) begin
            if (!i_mode) begin
                r_x     <= i_box_x;
                r_y     <= i_box_y;
                r_w     <= cl_w;
                r_h     <= cl_h;
                r_col   <= '0;
                r_row   <= '0;
                r_buf   <= '0;
                r_cnt   <= '0;
                r_found <= 1'b0;
            end else if (i_last_pixel) begin
                r_col   <= '0;
                r_row   <= '0;
                r_buf   <= '0;
                r_cnt   <= '0;
                r_found <= 1'b0;
            end else if (row_end) begin
                r_col   <= '0;
                r_row   <= r_row + HT_W'(1);
                r_buf   <= '0;
                r_cnt   <= '0;
                r_found <= r_found || qualify;
                if (qualify) begin
                    r_first <= r_row[ROW_W-1:0];
                end
            end else if (in_box) begin
                r_col <= r_col + COL_W'(1);
                r_buf <= n_buf;
                r_cnt <= n_cnt;
            end
        end
    end

endmodule

/* hdl/mpbt_queue.sv */
module mpbt_queue (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_push,
    input  mpbt_pkg::t_cmd i_cmd,
    output logic           o_full,
    input  logic           i_pop,
    output logic           o_valid,
    output mpbt_pkg::t_cmd o_cmd
);
    import mpbt_pkg::*;

    localparam int PW = $clog2(QDEPTH);

    t_cmd            r_ent [QDEPTH];
    logic [PW-1:0]   r_wp, r_rp;
    logic [PW:0]     r_cnt;

    assign o_full  = r_cnt == (PW+1)'(QDEPTH);
    assign o_valid = r_cnt != '0;
    assign o_cmd   = r_ent[r_rp];

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_ent[r_wp] <= i_cmd;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= '0;
            r_rp  <= '0;
            r_cnt <= '0;
        end else begin
            if (i_push) begin
                r_wp <= (32'(r_wp) == QDEPTH - 1) ? '0 : r_wp + PW'(1);
            end
            if (i_pop) begin
                r_rp <= (32'(r_rp) == QDEPTH - 1) ? '0 : r_rp + PW'(1);
            end
            r_cnt <= r_cnt + (PW+1)'(i_push) - (PW+1)'(i_pop);
        end
    end

`ifndef SYNTHESIS
    a_no_push_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_push |-> !o_full) else $error("push into full queue");
    a_no_pop_empty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_pop |-> o_valid) else $error("pop from empty queue");
    a_cnt_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        32'(r_cnt) <= QDEPTH) else $error("queue count out of range");
`endif

endmodule

/* hdl/mpbt_back.sv */
module mpbt_back (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  mpbt_pkg::t_cfg i_cfg,
    input  logic           i_q_valid,
    input  mpbt_pkg::t_cmd i_cmd,
    output logic           o_pop,
    output logic           o_valid,
    input  logic           i_ready,
    output logic [11:0]    o_out_x,
    output logic [11:0]    o_out_y,
    output logic [8:0]     o_out_width,
    output logic [8:0]     o_out_height
);
    import mpbt_pkg::*;

    typedef enum logic [2:0] {S_IDLE, S_ACC, S_SCAN, S_FIN, S_OUT} t_state;

    t_state               r_state;
    logic [MAX_WIDTH-1:0] r_mem [MAX_HEIGHT];
    logic [MAX_WIDTH-1:0] r_rdata;
    logic [HT_W-1:0]      r_cnt [MAX_WIDTH];
    logic [11:0]          r_x, r_y;
    logic [WD_W-1:0]      r_w;
    logic [HT_W-1:0]      r_h, r_nh, r_rows_valid;
    logic [ROW_W-1:0]     r_rd_row, r_pend_row;
    logic                 r_issue, r_pend;
    logic [8:0]           r_thr;
    logic [COL_W-1:0]     r_col, r_fst, r_lst;
    logic                 r_have;
    logic [11:0]          r_out_x, r_out_y;
    logic [8:0]           r_out_w, r_out_h;

    logic        we;
    logic [15:0] m16, first16, h16, row0_16, nh16, hthr16, thr16;
    logic [15:0] f16, l16, w16, lf16, rt16;
    logic        top_trim;

    assign o_pop = (r_state == S_IDLE) && i_q_valid;
    assign we    = o_pop && i_cmd.wr;

    always_ff @(posedge i_clk) begin
        if (we) begin
            r_mem[i_cmd.row] <= i_cmd.data;
        end
        r_rdata <= r_mem[r_rd_row];
    end

    always_comb begin
        m16      = {8'b0, i_cfg.margin};
        first16  = 16'(i_cmd.first);
        h16      = 16'(i_cmd.h);
        top_trim = i_cmd.found && (first16 > m16);
        row0_16  = top_trim ? first16 - m16 : 16'd0;
        nh16     = h16 - row0_16;
        hthr16   = {7'b0, i_cfg.hthr};
        thr16    = (hthr16 < nh16) ? hthr16 : nh16;

        f16  = 16'(r_fst);
        l16  = 16'(r_lst);
        w16  = 16'(r_w);
        lf16 = (f16 >= m16) ? f16 - m16 : 16'd0;
        rt16 = l16 + m16;
        if (rt16 >= w16) begin
            rt16 = w16 - 16'd1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_issue <= 1'b0;
            r_pend  <= 1'b0;
        end else begin
            case (r_state)
                S_IDLE: begin
                    if (o_pop && i_cmd.done) begin
                        r_x          <= i_cmd.x;
                        r_y          <= i_cmd.y + row0_16[11:0];
                        r_w          <= i_cmd.w;
                        r_h          <= i_cmd.h;
                        r_nh         <= HT_W'(nh16);
                        r_rows_valid <= i_cmd.rows_valid;
                        r_thr        <= thr16[8:0];
                        r_rd_row     <= row0_16[ROW_W-1:0];
                        r_issue      <= 1'b1;
                        r_pend       <= 1'b0;
                        r_col        <= '0;
                        r_fst        <= '0;
                        r_lst        <= '0;
                        r_have       <= 1'b0;
                        for (int j = 0; j < MAX_WIDTH; j++) begin
                            r_cnt[j] <= '0;
                        end
                        r_state <= S_ACC;
                    end
                end
                S_ACC: begin
                    r_pend     <= r_issue;
                    r_pend_row <= r_rd_row;
                    if (r_issue) begin
                        if (16'(r_rd_row) == 16'(r_h) - 16'd1) begin
                            r_issue <= 1'b0;
                        end else begin
                            r_rd_row <= r_rd_row + ROW_W'(1);
                        end
                    end
                    if (r_pend && (16'(r_pend_row) < 16'(r_rows_valid))) begin
                        for (int j = 0; j < MAX_WIDTH; j++) begin
                            r_cnt[j] <= r_cnt[j] + HT_W'(r_rdata[j]);
                        end
                    end
                    if (!r_issue && !r_pend) begin
                        r_state <= S_SCAN;
                    end
                end
                S_SCAN: begin
                    if (16'(r_cnt[0]) >= {7'b0, r_thr}) begin
                        if (!r_have) begin
                            r_fst <= r_col;
                        end
                        r_have <= 1'b1;
                        r_lst  <= r_col;
                    end
                    for (int j = 0; j < MAX_WIDTH - 1; j++) begin
                        r_cnt[j] <= r_cnt[j+1];
                    end
                    r_col <= r_col + COL_W'(1);
                    if (16'(r_col) == w16 - 16'd1) begin
                        r_state <= S_FIN;
                    end
                end
                S_FIN: begin
                    r_out_y <= r_y;
                    r_out_h <= 9'(r_nh);
                    if (rt16 > lf16) begin
                        r_out_x <= r_x + lf16[11:0];
                        r_out_w <= 9'(rt16 - lf16 + 16'd1);
                    end else begin
                        r_out_x <= r_x;
                        r_out_w <= 9'(r_w);
                    end
                    r_state <= S_OUT;
                end
                S_OUT: begin
                    if (i_ready) begin
                        r_state <= S_IDLE;
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    assign o_valid      = r_state == S_OUT;
    assign o_out_x      = r_out_x;
    assign o_out_y      = r_out_y;
    assign o_out_width  = r_out_w;
    assign o_out_height = r_out_h;

endmodule

/* bench/tb.sv */
module tb;
    import mpbt_pkg::*;

    localparam int WATCH_LIMIT = 20000;
    localparam int SETTLE      = 600;

    typedef struct {
        bit        mode;
        bit [11:0] x;
        bit [11:0] y;
        bit [8:0]  w;
        bit [8:0]  h;
        bit        on;
        bit        last;
    } t_item;

    typedef struct {
        logic [11:0] x;
        logic [11:0] y;
        logic [8:0]  w;
        logic [8:0]  h;
    } t_box;

    logic        i_clk;
    logic        i_rst_n;
    logic        i_cfg_we;
    logic [1:0]  i_cfg_idx;
    logic [8:0]  i_cfg_data;
    logic        i_valid;
    logic        o_ready;
    logic        i_mode;
    logic [11:0] i_box_x;
    logic [11:0] i_box_y;
    logic [8:0]  i_box_width;
    logic [8:0]  i_box_height;
    logic        i_pixel_on;
    logic        i_last_pixel;
    logic        o_valid;
    logic        i_ready;
    logic [11:0] o_out_x;
    logic [11:0] o_out_y;
    logic [8:0]  o_out_width;
    logic [8:0]  o_out_height;

    mask_projection_box_trim u_top (.*);

    t_item pending_items[$];
    t_box  trimmed_boxes[$];

    // predictor state
    bit        fg_mask[0:MAX_WIDTH*MAX_HEIGHT-1];
    bit [11:0] box_x_q, box_y_q;
    bit [8:0]  box_w_q, box_h_q;
    int        px_pos;
    int        vthr_q, hthr_q, margin_q;

    int  errors, n_pushed, n_taken, n_boxes, snd_idle, rcv_idle, long_hold, idle_cycles;
    bit  quiet, in_took;

    initial begin
        i_clk = 1'b0;
        forever #6 i_clk = ~i_clk;
    end

    task automatic report(input string what, input int got, input int want);
        $display("mismatch %s: got %0d expected %0d", what, got, want);
        errors++;
    endtask

    function automatic int clamp_dim(input int v);
        if (v == 0) return 1;
        if (v > 256) return 256;
        return v;
    endfunction

    function automatic bit px_at(input int idx);
        return (idx < px_pos) ? fg_mask[idx] : 1'b0;
    endfunction

    task automatic trim_step(input t_item it);
        int w, h, thr, r, c, cnt, off, row0, nh, fc, lc, lf, rt, nw;
        bit found;
        t_box res;
        if (!it.mode) begin
            box_x_q = it.x; box_y_q = it.y; box_w_q = it.w; box_h_q = it.h;
            px_pos = 0;
            return;
        end
        w = clamp_dim(box_w_q);
        h = clamp_dim(box_h_q);
        if (px_pos < w * h) begin
            fg_mask[px_pos] = it.on;
            px_pos++;
        end
        if (!it.last) return;
        res.x = box_x_q;
        res.y = box_y_q;
        thr = vthr_q < w ? vthr_q : w;
        found = 0;
        off = 0;
        for (r = 0; r < h && !found; r++) begin
            cnt = 0;
            for (c = 0; c < w; c++) cnt += px_at(r * w + c);
            if (cnt >= thr) begin
                found = 1;
                off = r - margin_q;
            end
        end
        row0 = 0;
        nh = h;
        if (found && off > 0) begin
            row0 = off;
            res.y = box_y_q + off;
            nh = h - off;
        end
        thr = hthr_q < nh ? hthr_q : nh;
        fc = -1;
        lc = -1;
        for (c = 0; c < w; c++) begin
            cnt = 0;
            for (r = row0; r < h; r++) cnt += px_at(r * w + c);
            if (cnt >= thr) begin
                if (fc < 0) fc = c;
                lc = c;
            end
        end
        lf = (fc < 0 ? 0 : fc) - margin_q;
        rt = (lc < 0 ? 0 : lc) + margin_q;
        if (lf < 0) lf = 0;
        if (rt >= w) rt = w - 1;
        nw = w;
        if (rt > lf) begin
            res.x = res.x + lf;
            nw = rt - lf + 1;
        end
        res.w = nw[8:0];
        res.h = nh[8:0];
        trimmed_boxes = {trimmed_boxes, res};
        px_pos = 0;
    endtask

    task automatic push_start(input bit [11:0] x, y, input bit [8:0] w, h);
        t_item it;
        it.mode = 0; it.x = x; it.y = y; it.w = w; it.h = h;
        it.on = $urandom_range(1); it.last = $urandom_range(1);
        pending_items = {pending_items, it};
        n_pushed++;
    endtask

    task automatic push_px(input bit on, last);
        t_item it;
        it.mode = 1; it.x = $urandom; it.y = $urandom; it.w = $urandom; it.h = $urandom;
        it.on = on; it.last = last;
        pending_items = {pending_items, it};
        n_pushed++;
    endtask

    // kind: 0 exact, 1 early last, 2 extra pixels, 3 no last, 4 exact then same box again
    task automatic add_box(input bit [8:0] w, h, input int kind);
        int ew, eh, n, i, r, c, r0, r1, c0, c1, pin, pout, pass;
        bit on;
        ew = clamp_dim(w);
        eh = clamp_dim(h);
        push_start($urandom, $urandom, w, h);
        r0 = $urandom_range(eh - 1); r1 = $urandom_range(eh - 1, r0);
        c0 = $urandom_range(ew - 1); c1 = $urandom_range(ew - 1, c0);
        pin = $urandom_range(100, 50);
        pout = $urandom_range(30);
        for (pass = 0; pass < (kind == 4 ? 2 : 1); pass++) begin
            n = ew * eh;
            if (kind == 1 && n > 1) n = $urandom_range(n - 1, 1);
            if (kind == 2) n = n + $urandom_range(3, 1);
            if (kind == 3) n = $urandom_range(n, 1);
            for (i = 0; i < n; i++) begin
                r = i / ew;
                c = i % ew;
                if (r >= r0 && r <= r1 && c >= c0 && c <= c1) on = $urandom_range(99) < pin;
                else on = $urandom_range(99) < pout;
                push_px(on, kind != 3 && i == n - 1);
            end
        end
    endtask

    task automatic set_cfg(input bit [8:0] v, hh, m);
        @(negedge i_clk);
        i_cfg_we = 1; i_cfg_idx = CFG_VTHR; i_cfg_data = v;
        vthr_q = v;
        @(negedge i_clk);
        i_cfg_idx = CFG_HTHR; i_cfg_data = hh;
        hthr_q = hh;
        @(negedge i_clk);
        i_cfg_idx = CFG_MARGIN; i_cfg_data = m;
        margin_q = m[7:0];
        @(negedge i_clk);
        i_cfg_we = 0;
    endtask

    task automatic wait_idle();
        while (!(n_taken == n_pushed && trimmed_boxes.size() == 0)) @(negedge i_clk);
        repeat (SETTLE) @(negedge i_clk);
    endtask

    task automatic random_phase(input int target);
        int start, sel;
        bit [8:0] w, h;
        start = n_pushed;
        while (n_pushed - start < target) begin
            sel = $urandom_range(599);
            w = $urandom_range(8, 1);
            h = $urandom_range(8, 1);
            if (sel == 0) begin w = 256; h = $urandom_range(2, 1); end
            else if (sel == 1) begin w = $urandom_range(2, 1); h = 256; end
            else if (sel == 2) begin w = 0; h = $urandom_range(511, 257); end
            else if (sel == 3) begin w = $urandom_range(511, 257); h = 0; end
            sel = $urandom_range(9);
            add_box(w, h, sel < 6 ? 0 : sel - 5);
            if ($urandom_range(19) == 0) push_px($urandom_range(1), $urandom_range(1));
        end
    endtask

    initial begin
        int ph;
        i_rst_n = 0; i_cfg_we = 0; i_cfg_idx = CFG_VTHR; i_cfg_data = 0;
        i_valid = 0; i_ready = 0; i_mode = 0; i_box_x = 0; i_box_y = 0;
        i_box_width = 0; i_box_height = 0; i_pixel_on = 0; i_last_pixel = 0;
        vthr_q = 10; hthr_q = 10; margin_q = 10;
        box_x_q = 0; box_y_q = 0; box_w_q = 0; box_h_q = 0; px_pos = 0;
        repeat (11) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1;

        // pixel straight after reset uses the zero box
        push_px(1, 1);
        push_start(12'hFFF, 12'hFFF, 0, 0);
        push_px(1, 1);
        push_start(12'h000, 12'h000, 9'd3, 9'd3);
        push_px(1, 0); push_px(1, 0);
        add_box(9'd2, 9'd2, 2);
        add_box(9'd3, 9'd2, 1);
        add_box(9'd2, 9'd3, 4);
        wait_idle();

        set_cfg(0, 0, 0);
        add_box(9'd4, 9'd4, 0);
        add_box(9'd256, 9'd1, 0);
        random_phase(30);
        wait_idle();

        set_cfg(9'h1FF, 9'h1FF, 9'h1FF);
        @(posedge i_clk);
        long_hold = 400;
        random_phase(40);
        wait_idle();

        set_cfg(1, 1, 0);
        random_phase(40);
        wait_idle();

        for (ph = 0; ph < 5; ph++) begin
            set_cfg($urandom_range(6), $urandom_range(6), $urandom_range(4));
            random_phase(30);
            wait_idle();
        end

        set_cfg(9'd256, 9'd1, 9'd255);
        random_phase(30);
        wait_idle();

        quiet = 1;
        set_cfg($urandom_range(511), $urandom_range(511), $urandom_range(511));
        random_phase(50);
        wait_idle();

        $display("sent %0d items over 11 register settings, checked %0d trimmed boxes",
                 n_taken, n_boxes);
        $display("covered clamped sizes, early and late last flags, repeats and full stalls");
        if (errors == 0) $display("[mask_projection_box_trim] OK");
        else $display("[mask_projection_box_trim] ERROR");
        $finish;
    end

    // sender
    always @(negedge i_clk) begin
        t_item it;
        if (!i_rst_n) begin
            i_valid <= 1'b0;
        end else if (i_valid && !in_took) begin
            // hold the offered item
        end else if (snd_idle > 0) begin
            snd_idle--;
            i_valid <= 1'b0;
        end else if (pending_items.size() > 0 && !quiet && $urandom_range(19) == 0) begin
            snd_idle = $urandom_range(15, 1) - 1;
            i_valid <= 1'b0;
        end else if (pending_items.size() > 0) begin
            it = pending_items.pop_front();
            i_valid <= 1'b1;
            i_mode <= it.mode;
            i_box_x <= it.x;
            i_box_y <= it.y;
            i_box_width <= it.w;
            i_box_height <= it.h;
            i_pixel_on <= it.on;
            i_last_pixel <= it.last;
        end else begin
            i_valid <= 1'b0;
        end
    end

    // receiver
    always @(negedge i_clk) begin
        if (long_hold > 0) begin
            long_hold--;
            i_ready <= 1'b0;
        end else if (rcv_idle > 0) begin
            rcv_idle--;
            i_ready <= 1'b0;
        end else if (!quiet && $urandom_range(15) == 0) begin
            rcv_idle = $urandom_range(15, 1) - 1;
            i_ready <= 1'b0;
        end else begin
            i_ready <= 1'b1;
        end
    end

    // monitor
    always @(posedge i_clk) begin
        t_item it;
        t_box want;
        in_took <= i_valid && o_ready;
        if (i_rst_n && i_valid && o_ready) begin
            it.mode = i_mode; it.x = i_box_x; it.y = i_box_y; it.w = i_box_width;
            it.h = i_box_height; it.on = i_pixel_on; it.last = i_last_pixel;
            trim_step(it);
            n_taken++;
        end
        if (i_rst_n && o_valid && i_ready) begin
            n_boxes++;
            if (trimmed_boxes.size() == 0) begin
                report("unexpected box", o_out_x, 0);
            end else begin
                want = trimmed_boxes.pop_front();
                if (o_out_x !== want.x) report("out_x", o_out_x, want.x);
                if (o_out_y !== want.y) report("out_y", o_out_y, want.y);
                if (o_out_width !== want.w) report("out_width", o_out_width, want.w);
                if (o_out_height !== want.h) report("out_height", o_out_height, want.h);
            end
        end
    end

    // watchdog
    always @(posedge i_clk) begin
        if ((i_valid && o_ready) || (o_valid && i_ready)) begin
            idle_cycles <= 0;
        end else if (idle_cycles >= WATCH_LIMIT) begin
            $display("timeout with %0d boxes outstanding", trimmed_boxes.size());
            $display("[mask_projection_box_trim] ERROR");
            $finish;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
    end

endmodule

/* sim.f */
hdl/mpbt_pkg.sv
hdl/mpbt_front.sv
hdl/mpbt_queue.sv
hdl/mpbt_back.sv
hdl/mask_projection_box_trim.sv
bench/tb.sv
